// ----- hw/rtl/vp9rtp_pkg.sv -----
// Shared types, token codes and phase routing for the VP9 RTP descriptor parser.
package vp9rtp_pkg;

    localparam int unsigned LenWidth = 16;
    localparam logic [LenWidth-1:0] LenMax = '1;

    // Token kind codes carried in token_kind.
    localparam logic [3:0] TK_NONE       = 4'd0;
    localparam logic [3:0] TK_HEADER     = 4'd1;
    localparam logic [3:0] TK_PICTURE_ID = 4'd2;
    localparam logic [3:0] TK_LAYER_IDX  = 4'd3;
    localparam logic [3:0] TK_TL0        = 4'd4;
    localparam logic [3:0] TK_REFDIFF    = 4'd5;
    localparam logic [3:0] TK_SS_HDR     = 4'd6;
    localparam logic [3:0] TK_WIDTH      = 4'd7;
    localparam logic [3:0] TK_HEIGHT     = 4'd8;
    localparam logic [3:0] TK_GOF_COUNT  = 4'd9;
    localparam logic [3:0] TK_GOF_ENTRY  = 4'd10;
    localparam logic [3:0] TK_GOF_DIFF   = 4'd11;

    // Descriptor route levels: after header, after picture id,
    // after layer indices / TL0, after the P_DIFF list.
    localparam logic [1:0] LVL_HDR  = 2'd0;
    localparam logic [1:0] LVL_PID  = 2'd1;
    localparam logic [1:0] LVL_LIDX = 2'd2;
    localparam logic [1:0] LVL_DIFF = 2'd3;

    typedef enum logic [14:0] {
        PH_HDR   = 15'b000000000000001,
        PH_PID1  = 15'b000000000000010,
        PH_PID2  = 15'b000000000000100,
        PH_LIDX  = 15'b000000000001000,
        PH_TL0   = 15'b000000000010000,
        PH_PDIFF = 15'b000000000100000,
        PH_SSHDR = 15'b000000001000000,
        PH_WHI   = 15'b000000010000000,
        PH_WLO   = 15'b000000100000000,
        PH_HHI   = 15'b000001000000000,
        PH_HLO   = 15'b000010000000000,
        PH_NG    = 15'b000100000000000,
        PH_GOF   = 15'b001000000000000,
        PH_GDIFF = 15'b010000000000000,
        PH_SKIP  = 15'b100000000000000
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } in_word_t;

    typedef struct packed {
        logic [3:0]          token_kind;
        logic [15:0]         token_value;
        logic [2:0]          temporal_id;
        logic                switch_up;
        logic [2:0]          spatial_id;
        logic [7:0]          item_index;
        logic                more_flag;
        logic                desc_done;
        logic                desc_error;
        logic [LenWidth-1:0] desc_length;
    } out_word_t;

    typedef struct packed {
        phase_t              phase;
        logic [7:0]          header_flags;
        logic [4:0]          ss_flags;        // {N_S-1, Y, G}
        logic [3:0]          layer_counter;
        logic [7:0]          gof_remaining;
        logic [7:0]          gof_entry_number;
        logic [1:0]          diff_remaining;
        logic [7:0]          held_high_byte;
        logic [LenWidth-1:0] byte_count;
    } state_t;

    localparam state_t StateReset = '{phase: PH_HDR, default: '0};

    // Next descriptor part following the given header-level part. The
    // scalability structure can follow any level, so it needs no level test.
    function automatic phase_t route(input logic [1:0] level, input logic [7:0] h);
        phase_t result;
        result = PH_SKIP;
        if (h[1]) begin
            result = PH_SSHDR;
        end
        if (level <= LVL_LIDX && h[4] && h[6]) begin
            result = PH_PDIFF;
        end
        if (level <= LVL_PID && h[5]) begin
            result = PH_LIDX;
        end
        if (level == LVL_HDR && h[7]) begin
            result = PH_PID1;
        end
        return result;
    endfunction

endpackage

// ----- hw/rtl/vp9rtp_step.sv -----
// Per-byte decode step: next parser state and the token that the byte produces.
module vp9rtp_step (
    input  vp9rtp_pkg::state_t    state_cur,
    input  vp9rtp_pkg::in_word_t  word_in,
    output vp9rtp_pkg::state_t    state_next,
    output logic                  tok_valid,
    output vp9rtp_pkg::out_word_t tok_word
);

    logic [7:0] b;
    logic       eop;
    logic       tok;
    logic       done;
    logic       err;
    logic [3:0] layer_inc;
    logic [7:0] gof_rem_dec;
    logic [1:0] diff_dec;
    vp9rtp_pkg::state_t    st;
    vp9rtp_pkg::out_word_t ow;
    vp9rtp_pkg::phase_t    next_phase;

    always_comb begin
        b           = word_in.rx_byte;
        eop         = word_in.end_of_packet;
        st          = state_cur;
        ow          = '0;
        tok         = 1'b0;
        next_phase  = vp9rtp_pkg::PH_SKIP;
        layer_inc   = state_cur.layer_counter + 4'd1;
        gof_rem_dec = state_cur.gof_remaining - 8'd1;
        diff_dec    = state_cur.diff_remaining - 2'd1;
        done        = 1'b0;
        err         = 1'b0;

        if (state_cur.phase == vp9rtp_pkg::PH_SKIP) begin
            next_phase = vp9rtp_pkg::PH_SKIP;
        end else begin
            if (state_cur.byte_count != vp9rtp_pkg::LenMax) begin
                st.byte_count = state_cur.byte_count + 1'b1;
            end
            case (state_cur.phase)
                vp9rtp_pkg::PH_HDR: begin
                    st.header_flags = b;
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_HEADER;
                    ow.token_value = {8'd0, b};
                    next_phase = vp9rtp_pkg::route(vp9rtp_pkg::LVL_HDR, b);
                end
                vp9rtp_pkg::PH_PID1: begin
                    if (b[7]) begin
                        st.held_high_byte = b;
                        next_phase = vp9rtp_pkg::PH_PID2;
                    end else begin
                        tok = 1'b1;
                        ow.token_kind = vp9rtp_pkg::TK_PICTURE_ID;
                        ow.token_value = {9'd0, b[6:0]};
                        next_phase = vp9rtp_pkg::route(vp9rtp_pkg::LVL_PID,
                                                       state_cur.header_flags);
                    end
                end
                vp9rtp_pkg::PH_PID2: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_PICTURE_ID;
                    ow.more_flag = 1'b1;
                    ow.token_value = {1'b0, state_cur.held_high_byte[6:0], b};
                    next_phase = vp9rtp_pkg::route(vp9rtp_pkg::LVL_PID,
                                                   state_cur.header_flags);
                end
                vp9rtp_pkg::PH_LIDX: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_LAYER_IDX;
                    ow.token_value = {8'd0, b};
                    ow.temporal_id = b[7:5];
                    ow.switch_up = b[4];
                    ow.spatial_id = b[3:1];
                    ow.more_flag = b[0];
                    next_phase = state_cur.header_flags[4]
                        ? vp9rtp_pkg::route(vp9rtp_pkg::LVL_LIDX, state_cur.header_flags)
                        : vp9rtp_pkg::PH_TL0;
                end
                vp9rtp_pkg::PH_TL0: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_TL0;
                    ow.token_value = {8'd0, b};
                    next_phase = vp9rtp_pkg::route(vp9rtp_pkg::LVL_LIDX,
                                                   state_cur.header_flags);
                end
                vp9rtp_pkg::PH_PDIFF: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_REFDIFF;
                    ow.token_value = {9'd0, b[7:1]};
                    ow.more_flag = b[0];
                    next_phase = b[0] ? vp9rtp_pkg::PH_PDIFF
                        : vp9rtp_pkg::route(vp9rtp_pkg::LVL_DIFF, state_cur.header_flags);
                end
                vp9rtp_pkg::PH_SSHDR: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_SS_HDR;
                    ow.token_value = {8'd0, b};
                    st.ss_flags = {b[7:5], b[4], b[3]};
                    st.layer_counter = 4'd0;
                    if (b[4]) begin
                        next_phase = vp9rtp_pkg::PH_WHI;
                    end else if (b[3]) begin
                        next_phase = vp9rtp_pkg::PH_NG;
                    end else begin
                        next_phase = vp9rtp_pkg::PH_SKIP;
                    end
                end
                vp9rtp_pkg::PH_WHI: begin
                    st.held_high_byte = b;
                    next_phase = vp9rtp_pkg::PH_WLO;
                end
                vp9rtp_pkg::PH_HHI: begin
                    st.held_high_byte = b;
                    next_phase = vp9rtp_pkg::PH_HLO;
                end
                vp9rtp_pkg::PH_WLO: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_WIDTH;
                    ow.item_index = {4'd0, state_cur.layer_counter};
                    ow.token_value = {state_cur.held_high_byte, b};
                    next_phase = vp9rtp_pkg::PH_HHI;
                end
                vp9rtp_pkg::PH_HLO: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_HEIGHT;
                    ow.item_index = {4'd0, state_cur.layer_counter};
                    ow.token_value = {state_cur.held_high_byte, b};
                    st.layer_counter = layer_inc;
                    if ({1'b0, layer_inc} < {2'd0, state_cur.ss_flags[4:2]} + 5'd1) begin
                        next_phase = vp9rtp_pkg::PH_WHI;
                    end else if (state_cur.ss_flags[0]) begin
                        next_phase = vp9rtp_pkg::PH_NG;
                    end else begin
                        next_phase = vp9rtp_pkg::PH_SKIP;
                    end
                end
                vp9rtp_pkg::PH_NG: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_GOF_COUNT;
                    ow.token_value = {8'd0, b};
                    st.gof_remaining = b;
                    st.gof_entry_number = 8'd0;
                    next_phase = (b != 8'd0) ? vp9rtp_pkg::PH_GOF : vp9rtp_pkg::PH_SKIP;
                end
                vp9rtp_pkg::PH_GOF: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_GOF_ENTRY;
                    ow.item_index = state_cur.gof_entry_number;
                    ow.temporal_id = b[7:5];
                    ow.switch_up = b[4];
                    ow.token_value = {14'd0, b[3:2]};
                    st.diff_remaining = b[3:2];
                    if (b[3:2] != 2'd0) begin
                        next_phase = vp9rtp_pkg::PH_GDIFF;
                    end else begin
                        st.gof_entry_number = state_cur.gof_entry_number + 8'd1;
                        st.gof_remaining = gof_rem_dec;
                        next_phase = (gof_rem_dec == 8'd0) ? vp9rtp_pkg::PH_SKIP
                                                          : vp9rtp_pkg::PH_GOF;
                    end
                end
                vp9rtp_pkg::PH_GDIFF: begin
                    tok = 1'b1;
                    ow.token_kind = vp9rtp_pkg::TK_GOF_DIFF;
                    ow.item_index = state_cur.gof_entry_number;
                    ow.token_value = {8'd0, b};
                    st.diff_remaining = diff_dec;
                    if (diff_dec != 2'd0) begin
                        next_phase = vp9rtp_pkg::PH_GDIFF;
                    end else begin
                        st.gof_entry_number = state_cur.gof_entry_number + 8'd1;
                        st.gof_remaining = gof_rem_dec;
                        next_phase = (gof_rem_dec == 8'd0) ? vp9rtp_pkg::PH_SKIP
                                                          : vp9rtp_pkg::PH_GOF;
                    end
                end
                default: begin
                    next_phase = vp9rtp_pkg::PH_SKIP;
                end
            endcase
            done = (next_phase == vp9rtp_pkg::PH_SKIP);
            err  = eop && !done;
            tok  = tok || err;
        end

        st.phase = next_phase;
        ow.desc_done = done;
        ow.desc_error = err;
        ow.desc_length = st.byte_count;

        // The final byte of a packet always rearms the parser.
        state_next = eop ? vp9rtp_pkg::StateReset : st;
        tok_valid  = tok;
        tok_word   = ow;
    end

endmodule

// ----- hw/rtl/vp9_rtp_descriptor_parser_top.sv -----
// Top level of the VP9 RTP payload descriptor parser with its input and result registers.
//
// The parser takes one payload byte per word on the s_ channel and returns one token
// word on the m_ channel for every descriptor field it completes: the header byte,
// the picture id, layer indices, TL0PICIDX, each flexible-mode P_DIFF, and in the
// scalability structure its header byte, the per-layer width and height, N_G, each
// group-of-frames entry and its reference diffs. The token that finishes the descriptor
// has desc_done set; the remaining payload bytes are then swallowed until end_of_packet,
// after which the next byte is taken as a fresh header. A packet that ends before the
// descriptor is complete yields a token with desc_error set (of kind none if the byte
// itself completed nothing). Bytes that only hold the high half of a field give no
// word. The block sustains one byte per clock while m_ready does not stall it: a byte
// is captured in the input register, decoded by the step logic against the parse state
// and written into the result register, which presents its token on m_. A stall on
// m_ready holds the result register and the input register and then back-pressures
// s_ready; no word is lost or repeated.
module vp9_rtp_descriptor_parser_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  vp9rtp_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vp9rtp_pkg::out_word_t m_data
);

    logic                  in_valid_reg;
    vp9rtp_pkg::in_word_t  in_word_reg;
    logic                  m_valid_reg;
    vp9rtp_pkg::out_word_t m_data_reg;
    vp9rtp_pkg::state_t    state_reg;
    vp9rtp_pkg::state_t    state_next;
    logic                  tok_valid;
    vp9rtp_pkg::out_word_t tok_word;
    logic                  out_free;
    logic                  advance;

    // The result register can be loaded when it is empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;
    // A held byte is decoded as soon as the result register is free, whether or not it yields a token.
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    vp9rtp_step u_step (
        .state_cur  (state_reg),
        .word_in    (in_word_reg),
        .state_next (state_next),
        .tok_valid  (tok_valid),
        .tok_word   (tok_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= vp9rtp_pkg::StateReset;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                m_valid_reg <= advance && tok_valid;
            end
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance && tok_valid) begin
            m_data_reg <= tok_word;
        end
    end

    // A token of kind none is only ever sent to report an early packet end.
    a_none_is_error : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind == vp9rtp_pkg::TK_NONE |-> m_data.desc_error)
        else $error("token of kind none without an error flag");

    // A descriptor cannot be both complete and cut short.
    a_done_xor_error : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.desc_done && m_data.desc_error))
        else $error("token flagged both done and error");

    // Every token comes from at least one descriptor byte.
    a_length_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.desc_length != '0)
        else $error("token reports a zero descriptor length");

    // The parse state only moves when a held byte is decoded.
    a_state_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("parse state changed without a decoded byte");

endmodule
